[rtl/core/udpcv_pkg.sv]
package udpcv_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned SUM_W  = 19;   // room for six 16-bit operands

    localparam logic [WORD_W-1:0] IPV4_PROTO_UDP     = 16'd17;
    localparam logic [WORD_W-1:0] DNS_PORT_RST       = 16'd53;
    localparam logic [WORD_W-1:0] DHCP_CLIENT_RST    = 16'd68;
    localparam logic [WORD_W-1:0] DHCP_SERVER_RST    = 16'd67;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_CSUM     = 2'd1,
        ST_BAD_PORT     = 2'd2,
        ST_BAD_DHCP_SRC = 2'd3
    } status_t;

    // Position within the datagram; saturates once past the UDP header
    typedef enum logic [2:0] {
        IDX_SRC_PORT = 3'd0,
        IDX_DST_PORT = 3'd1,
        IDX_LENGTH   = 3'd2,
        IDX_CHECKSUM = 3'd3,
        IDX_PAYLOAD  = 3'd4
    } word_idx_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DNS_PORT    = 2'd0,
        REG_DHCP_CLIENT = 2'd1,
        REG_DHCP_SERVER = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] data_word;
        logic              odd_byte;
        logic              last;
        logic [ADDR_W-1:0] src_address;
        logic [ADDR_W-1:0] dst_address;
    } item_t;

    // Datagram summary handed from the accumulator to the dispatch stage
    typedef struct packed {
        logic              last;
        logic              mode;
        logic [WORD_W-1:0] checksum;
        logic [WORD_W-1:0] recv_csum;
        logic [WORD_W-1:0] src_port;
        logic [WORD_W-1:0] dst_port;
    } dgram_t;

    // End-around carry fold of a wide binary sum back to 16 bits
    function automatic logic [WORD_W-1:0] oc_fold(input logic [SUM_W-1:0] s);
        logic [WORD_W:0] f1;
        f1 = {1'b0, s[WORD_W-1:0]} + {{(WORD_W+1-(SUM_W-WORD_W)){1'b0}}, s[SUM_W-1:WORD_W]};
        return f1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, f1[WORD_W]};
    endfunction

endpackage

[rtl/core/udpcv_in_stage.sv]
module udpcv_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  udpcv_pkg::item_t in_item,
    input  logic            advance,
    output logic            item_valid,
    output udpcv_pkg::item_t item
);
    import udpcv_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Accept whenever the held word is empty or moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

[rtl/core/udpcv_accum.sv]
module udpcv_accum (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  udpcv_pkg::item_t     item,
    output udpcv_pkg::dgram_t    dgram,
    output udpcv_pkg::word_idx_t idx
);
    import udpcv_pkg::*;

    logic [WORD_W-1:0] sum_reg;
    logic              mode_reg;
    word_idx_t         idx_reg;
    logic [WORD_W-1:0] src_port_reg;
    logic [WORD_W-1:0] dst_port_reg;
    logic [WORD_W-1:0] rx_csum_reg;

    logic              first;
    logic              mode;
    logic [WORD_W-1:0] word;
    logic [ADDR_W-1:0] src_eff;
    logic [SUM_W-1:0]  sum_wide;
    logic [WORD_W-1:0] sum_next;
    word_idx_t         idx_next;

    function automatic logic [SUM_W-1:0] ext(input logic [WORD_W-1:0] v);
        return {{(SUM_W-WORD_W){1'b0}}, v};
    endfunction

    assign first = (idx_reg == IDX_SRC_PORT);
    assign mode  = first ? item.action : mode_reg;

    // Odd trailing byte: pad with a zero low byte
    assign word    = (item.last && item.odd_byte) ? {item.data_word[15:8], 8'h00}
                                                  : item.data_word;
    // Transmit mode leaves the source address out of the pseudo-header
    assign src_eff = mode ? item.src_address : '0;

    // One multi-operand add per word, then end-around fold
    always_comb begin
        if (first) begin
            sum_wide = ext(item.dst_address[31:16]) + ext(item.dst_address[15:0])
                     + ext(src_eff[31:16]) + ext(src_eff[15:0])
                     + ext(IPV4_PROTO_UDP) + ext(word);
        end else begin
            case (idx_reg)
                IDX_LENGTH:   sum_wide = ext(sum_reg) + ext(word) + ext(word);
                IDX_CHECKSUM: sum_wide = ext(sum_reg);
                default:      sum_wide = ext(sum_reg) + ext(word);
            endcase
        end
    end

    assign sum_next = oc_fold(sum_wide);
    assign idx_next = (idx_reg == IDX_PAYLOAD) ? IDX_PAYLOAD
                                               : word_idx_t'(idx_reg + 3'd1);

    // Summary seen on this word; only meaningful with last set
    always_comb begin
        dgram.last      = item.last;
        dgram.mode      = mode;
        dgram.checksum  = ~sum_next;
        dgram.recv_csum = (idx_reg == IDX_CHECKSUM) ? word : rx_csum_reg;
        dgram.src_port  = first ? word : src_port_reg;
        dgram.dst_port  = (idx_reg == IDX_DST_PORT) ? word : dst_port_reg;
    end

    assign idx = idx_reg;

    // Datagram state; everything returns to zero after the last word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            mode_reg     <= 1'b0;
            idx_reg      <= IDX_SRC_PORT;
            src_port_reg <= '0;
            dst_port_reg <= '0;
            rx_csum_reg  <= '0;
        end else if (fire) begin
            if (item.last) begin
                sum_reg      <= '0;
                mode_reg     <= 1'b0;
                idx_reg      <= IDX_SRC_PORT;
                src_port_reg <= '0;
                dst_port_reg <= '0;
                rx_csum_reg  <= '0;
            end else begin
                sum_reg      <= sum_next;
                mode_reg     <= mode;
                idx_reg      <= idx_next;
                src_port_reg <= dgram.src_port;
                dst_port_reg <= dgram.dst_port;
                rx_csum_reg  <= dgram.recv_csum;
            end
        end
    end

endmodule

[rtl/core/udpcv_dispatch.sv]
module udpcv_dispatch (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_addr,
    input  logic [15:0]              cfg_wdata,
    input  logic                     in_valid,
    input  udpcv_pkg::dgram_t        dgram,
    output logic                     advance,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [15:0]              res_checksum,
    output udpcv_pkg::status_t       res_status,
    output logic [15:0]              res_src_port,
    output logic [15:0]              res_dst_port
);
    import udpcv_pkg::*;

    logic [WORD_W-1:0] dns_port_reg;
    logic [WORD_W-1:0] dhcp_client_reg;
    logic [WORD_W-1:0] dhcp_server_reg;

    logic              valid_reg;
    logic [WORD_W-1:0] csum_reg;
    status_t           status_reg;
    logic [WORD_W-1:0] src_port_reg;
    logic [WORD_W-1:0] dst_port_reg;
    status_t           status_next;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dns_port_reg    <= DNS_PORT_RST;
            dhcp_client_reg <= DHCP_CLIENT_RST;
            dhcp_server_reg <= DHCP_SERVER_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_DNS_PORT:    dns_port_reg    <= cfg_wdata;
                REG_DHCP_CLIENT: dhcp_client_reg <= cfg_wdata;
                REG_DHCP_SERVER: dhcp_server_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Receive mode: checksum compare first, then destination port dispatch; transmit mode is always OK
    always_comb begin
        if (!dgram.mode) begin
            status_next = ST_OK;
        end else if (dgram.recv_csum != dgram.checksum) begin
            status_next = ST_BAD_CSUM;
        end else if (dgram.dst_port == dns_port_reg) begin
            status_next = ST_OK;
        end else if (dgram.dst_port == dhcp_client_reg) begin
            status_next = (dgram.src_port == dhcp_server_reg) ? ST_OK : ST_BAD_DHCP_SRC;
        end else begin
            status_next = ST_BAD_PORT;
        end
    end

    // Result register frees up when empty or taken
    assign advance = !valid_reg || res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid && dgram.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid && dgram.last) begin
            csum_reg     <= dgram.checksum;
            status_reg   <= status_next;
            src_port_reg <= dgram.src_port;
            dst_port_reg <= dgram.dst_port;
        end
    end

    assign res_valid    = valid_reg;
    assign res_checksum = csum_reg;
    assign res_status   = status_reg;
    assign res_src_port = src_port_reg;
    assign res_dst_port = dst_port_reg;

endmodule

[rtl/core/udp_checksum_verify_dispatch_top.sv]
// Path: the last word passes the input register, then the result register; m_tvalid
// rises once the result register has taken it. Throughput: one word per cycle
// while no result waits on m_tready; the single end-around add per word sets the rate.
// Reset: aresetn is synchronous, active low; it empties both registers, clears
// the datagram state and restores the port registers to 53, 68 and 67.
module udp_checksum_verify_dispatch_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // datagram words in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // data_word[15:0], src_address[47:16], dst_address[79:48]
    input  logic        s_tlast,
    input  logic [1:0]  s_tuser,   // action[0], odd_byte[1]
    // results out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // checksum[15:0], status[17:16], src_port[33:18],
                                   // dst_port[49:34], zero[55:50]
);
    import udpcv_pkg::*;

    item_t     in_item;
    item_t     item;
    logic      item_valid;
    logic      advance;
    dgram_t    dgram;
    word_idx_t idx;

    logic [15:0] res_checksum;
    status_t     res_status;
    logic [15:0] res_src_port;
    logic [15:0] res_dst_port;

    always_comb begin
        in_item.action      = s_tuser[0];
        in_item.odd_byte    = s_tuser[1];
        in_item.last        = s_tlast;
        in_item.data_word   = s_tdata[15:0];
        in_item.src_address = s_tdata[47:16];
        in_item.dst_address = s_tdata[79:48];
    end

    udpcv_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    udpcv_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (item_valid && advance),
        .item    (item),
        .dgram   (dgram),
        .idx     (idx)
    );

    udpcv_dispatch u_dispatch (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (item_valid),
        .dgram        (dgram),
        .advance      (advance),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_checksum (res_checksum),
        .res_status   (res_status),
        .res_src_port (res_src_port),
        .res_dst_port (res_dst_port)
    );

    assign m_tdata = {6'b0, res_dst_port, res_src_port, res_status, res_checksum};

    // Transmit-mode datagrams always finish with an OK status
    a_tx_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_valid && dgram.last && !dgram.mode)
        |=> (m_tvalid && m_tdata[17:16] == ST_OK))
        else $error("transmit result without OK status");

    // The word index restarts after the last word of a datagram
    a_idx_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_valid && dgram.last) |=> (idx == IDX_SRC_PORT))
        else $error("word index not cleared after last word");

    // A held input word stays put while the result side stalls
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && !advance) |=> (item_valid && $stable(item)))
        else $error("held input word lost during stall");

endmodule
